/* rtl/core/vtp_pkg.sv */
`default_nettype none
package vtp_pkg;

	localparam int unsigned ViewWidthDefault = 2560;
	localparam int unsigned ViewHeightDefault = 1440;

	localparam int unsigned RegCount = 8;
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	typedef enum logic [RegIdxW-1:0] {
		REG_COEF_X = 3'd0,
		REG_COEF_Y = 3'd1,
		REG_COEF_Z = 3'd2,
		REG_COEF_W = 3'd3,
		REG_OFS_X = 3'd4,
		REG_OFS_Y = 3'd5,
		REG_OFS_Z = 3'd6,
		REG_VIEW = 3'd7
	} reg_idx_t;

	// Dot products are Q.28 sums of three 33x16 products plus a constant term.
	localparam int unsigned DotW = 52;
	// Quotient magnitude before saturation: up to 2^32 integer part, 16 fraction bits.
	localparam int unsigned QuoW = 50;
	localparam int unsigned QuoSteps = 68;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW = 2;

	typedef struct packed {
		logic signed [DotW-1:0] nx;
		logic signed [DotW-1:0] ny;
		logic signed [DotW-1:0] nz;
		logic signed [DotW-1:0] w;
	} dot_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -68'sh0_0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/vtp_front.sv */
`default_nettype none
// Offset add and 4x4 matrix product, three pipeline stages.
module vtp_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     valid,
	input  wire logic signed [31:0]       vertex_x,
	input  wire logic signed [31:0]       vertex_y,
	input  wire logic signed [31:0]       vertex_z,
	input  wire logic [63:0]              coef [4],
	input  wire logic signed [31:0]       ofs_x,
	input  wire logic signed [31:0]       ofs_y,
	input  wire logic signed [31:0]       ofs_z,
	output logic                          out_valid,
	output vtp_pkg::dot_t                 out_dot
);

	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] x_s1, y_s1, z_s1;
	logic signed [48:0] p_s2 [4][3];
	logic signed [15:0] c_s2 [4];
	vtp_pkg::dot_t      dot_s3;
	logic signed [vtp_pkg::DotW-1:0] sum [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= 33'(vertex_x) + 33'(ofs_x);
		y_s1 <= 33'(vertex_y) + 33'(ofs_y);
		z_s1 <= 33'(vertex_z) + 33'(ofs_z);
		for (int r = 0; r < 4; r++) begin
			p_s2[r][0] <= x_s1 * $signed(coef[r][15:0]);
			p_s2[r][1] <= y_s1 * $signed(coef[r][31:16]);
			p_s2[r][2] <= z_s1 * $signed(coef[r][47:32]);
			c_s2[r] <= $signed(coef[r][63:48]);
		end
		dot_s3.nx <= sum[0];
		dot_s3.ny <= sum[1];
		dot_s3.nz <= sum[2];
		dot_s3.w <= sum[3];
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = vtp_pkg::DotW'(p_s2[r][0]) + vtp_pkg::DotW'(p_s2[r][1])
				+ vtp_pkg::DotW'(p_s2[r][2])
				+ {{(vtp_pkg::DotW-32){c_s2[r][15]}}, c_s2[r], 16'd0};
		end
	end

	assign out_valid = v_s3;
	assign out_dot = dot_s3;

endmodule
`default_nettype wire

/* rtl/core/vtp_fifo.sv */
`default_nettype none
// Short queue between the matrix front and the divide back. The back never
// stalls, so it only absorbs the skew; it keeps the two sides decoupled.
module vtp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire vtp_pkg::dot_t wdata,
	output logic               pop,
	output vtp_pkg::dot_t      rdata
);

	vtp_pkg::dot_t mem [vtp_pkg::FifoDepth];
	logic [vtp_pkg::FifoPtrW-1:0] wp_q, rp_q;
	logic [vtp_pkg::FifoPtrW:0]   cnt_q;

	assign pop = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	assign rdata = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (vtp_pkg::FifoPtrW+1)'(push) - (vtp_pkg::FifoPtrW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/vtp_back.sv */
`default_nettype none
// Perspective divide as a pipeline of restoring steps, one quotient bit per
// stage, followed by saturation and optional viewport mapping.
module vtp_back #(
	parameter int unsigned VIEW_WIDTH = vtp_pkg::ViewWidthDefault,
	parameter int unsigned VIEW_HEIGHT = vtp_pkg::ViewHeightDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	input  wire vtp_pkg::dot_t dot,
	input  wire logic          viewport_on,
	output logic               done,
	output logic signed [31:0] result_x,
	output logic signed [31:0] result_y,
	output logic signed [31:0] result_z,
	output logic               w_was_zero
);

	localparam int unsigned N = vtp_pkg::QuoSteps;
	localparam int unsigned DW = vtp_pkg::DotW;
	// Dividend n*2^16 magnitude fits in DW+16 bits; shifted out MSB first.
	localparam int unsigned NW = DW + 16;

	typedef struct packed {
		logic                 v;
		logic                 wz;
		logic [DW-1:0]        den;
		logic [2:0]           neg;
		logic [2:0][NW-1:0]   num;
		logic [2:0][DW:0]     rem;
		logic [2:0][NW-1:0]   quo;
		logic [2:0][DW-1:0]   fl;
	} st_t;

	st_t s_q [N+1];
	st_t s_n [N+1];

	function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] a);
		return a[DW-1] ? DW'(-a) : DW'(a);
	endfunction

	always_comb begin
		logic signed [DW-1:0] nn [3];
		nn[0] = dot.nx;
		nn[1] = dot.ny;
		nn[2] = dot.nz;
		s_n[0].v = valid;
		s_n[0].wz = (dot.w == '0);
		s_n[0].den = absv(dot.w);
		for (int k = 0; k < 3; k++) begin
			s_n[0].neg[k] = nn[k][DW-1] ^ dot.w[DW-1];
			s_n[0].num[k] = {absv(nn[k]), 16'd0};
			s_n[0].rem[k] = '0;
			s_n[0].quo[k] = '0;
			s_n[0].fl[k] = nn[k] >>> 12;
		end
		for (int i = 1; i <= N; i++) begin
			s_n[i] = s_q[i-1];
			for (int k = 0; k < 3; k++) begin
				logic [DW+1:0] r2;
				r2 = {s_q[i-1].rem[k], s_q[i-1].num[k][NW-1]};
				s_n[i].num[k] = {s_q[i-1].num[k][NW-2:0], 1'b0};
				if (r2 >= {2'b00, s_q[i-1].den}) begin
					s_n[i].rem[k] = (DW+1)'(r2 - {2'b00, s_q[i-1].den});
					s_n[i].quo[k] = {s_q[i-1].quo[k][NW-2:0], 1'b1};
				end else begin
					s_n[i].rem[k] = (DW+1)'(r2);
					s_n[i].quo[k] = {s_q[i-1].quo[k][NW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) s_q[i] <= '0;
		end else begin
			for (int i = 0; i <= N; i++) s_q[i] <= s_n[i];
		end
	end

	// Saturate, stage one of the tail.
	logic               v_t1, wz_t1, v_t2;
	logic signed [31:0] r_t1 [3];
	logic signed [31:0] o_t2 [3];
	logic               wz_t2;
	logic signed [67:0] mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [NW-1:0] q;
			q = s_q[N].quo[k];
			if (q > (NW'(1) << 48)) q = NW'(1) << 48;
			mag[k] = s_q[N].neg[k] ? -$signed({1'b0, 67'(q)}) : $signed({1'b0, 67'(q)});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
		end else begin
			v_t1 <= s_q[N].v;
			v_t2 <= v_t1;
		end
	end

	always_ff @(posedge clk) begin
		wz_t1 <= s_q[N].wz;
		for (int k = 0; k < 3; k++) begin
			r_t1[k] <= s_q[N].wz ? vtp_pkg::sat32(68'($signed(s_q[N].fl[k])))
				: vtp_pkg::sat32(mag[k]);
		end
	end

	// Viewport mapping, stage two of the tail.
	logic signed [48:0] vx, vy;
	always_comb begin
		vx = (49'(r_t1[0]) + 49'sd65536) * $signed({1'b0, 15'(VIEW_WIDTH)});
		vy = (49'(r_t1[1]) + 49'sd65536) * $signed({1'b0, 15'(VIEW_HEIGHT)});
	end

	always_ff @(posedge clk) begin
		wz_t2 <= wz_t1;
		o_t2[2] <= r_t1[2];
		if (viewport_on) begin
			o_t2[0] <= vtp_pkg::sat32(68'(vx >>> 1));
			o_t2[1] <= vtp_pkg::sat32(68'(vy >>> 1));
		end else begin
			o_t2[0] <= r_t1[0];
			o_t2[1] <= r_t1[1];
		end
	end

	assign done = v_t2;
	assign result_x = o_t2[0];
	assign result_y = o_t2[1];
	assign result_z = o_t2[2];
	assign w_was_zero = wz_t2;

endmodule
`default_nettype wire

/* rtl/core/vertex_transform_project.sv */
`default_nettype none
// Vertex transform: offset add, 4x4 Q4.12 matrix, perspective divide and
// optional viewport mapping. One vertex is taken every cycle (busy stays
// low); each result appears on the result ports for one cycle with done high,
// after the front stages, the queue, the divide and the tail, and cannot be
// held off. The divide is a pipeline of one quotient bit per stage.
module vertex_transform_project #(
	parameter int unsigned VIEW_WIDTH = vtp_pkg::ViewWidthDefault,
	parameter int unsigned VIEW_HEIGHT = vtp_pkg::ViewHeightDefault
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [31:0]             vertex_x,
	input  wire logic signed [31:0]             vertex_y,
	input  wire logic signed [31:0]             vertex_z,
	input  wire logic                           cfg_we,
	input  wire logic [vtp_pkg::RegIdxW-1:0]    cfg_idx,
	input  wire logic [vtp_pkg::CfgDataW-1:0]   cfg_data,
	output logic                                done,
	output logic signed [31:0]                  result_x,
	output logic signed [31:0]                  result_y,
	output logic signed [31:0]                  result_z,
	output logic                                w_was_zero
);

	logic [63:0]        coef_q [4];
	logic signed [31:0] ofs_x_q, ofs_y_q, ofs_z_q;
	logic               view_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= 64'h0000_0000_0000_1000;
			coef_q[1] <= 64'h0000_0000_1000_0000;
			coef_q[2] <= 64'h0000_1000_0000_0000;
			coef_q[3] <= 64'h1000_0000_0000_0000;
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			ofs_z_q <= '0;
			view_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (vtp_pkg::reg_idx_t'(cfg_idx))
				vtp_pkg::REG_COEF_X: coef_q[0] <= cfg_data;
				vtp_pkg::REG_COEF_Y: coef_q[1] <= cfg_data;
				vtp_pkg::REG_COEF_Z: coef_q[2] <= cfg_data;
				vtp_pkg::REG_COEF_W: coef_q[3] <= cfg_data;
				vtp_pkg::REG_OFS_X: ofs_x_q <= cfg_data[31:0];
				vtp_pkg::REG_OFS_Y: ofs_y_q <= cfg_data[31:0];
				vtp_pkg::REG_OFS_Z: ofs_z_q <= cfg_data[31:0];
				vtp_pkg::REG_VIEW: view_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic          f_valid, q_pop;
	vtp_pkg::dot_t f_dot, q_dot;

	vtp_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(start),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.coef(coef_q), .ofs_x(ofs_x_q), .ofs_y(ofs_y_q), .ofs_z(ofs_z_q),
		.out_valid(f_valid), .out_dot(f_dot)
	);

	vtp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .wdata(f_dot),
		.pop(q_pop), .rdata(q_dot)
	);

	vtp_back #(.VIEW_WIDTH(VIEW_WIDTH), .VIEW_HEIGHT(VIEW_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .valid(q_pop), .dot(q_dot),
		.viewport_on(view_q), .done(done),
		.result_x(result_x), .result_y(result_y), .result_z(result_z),
		.w_was_zero(w_was_zero)
	);

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               wz;
	} projected_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	logic cfg_we = 1'b0;
	logic [vtp_pkg::RegIdxW-1:0] cfg_idx = '0;
	logic [vtp_pkg::CfgDataW-1:0] cfg_data = '0;
	logic busy, done, w_was_zero;
	logic signed [31:0] result_x, result_y, result_z;

	vertex_transform_project i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .result_x(result_x), .result_y(result_y),
		.result_z(result_z), .w_was_zero(w_was_zero)
	);

	always #10 clk = ~clk;

	// Shadow of the configuration registers.
	logic [63:0] coef [4];
	logic signed [63:0] ofs [3];
	logic view_on;

	// Pending vertices and expected results, each a ring with read and write counts.
	localparam int ListLen = 4096;
	vertex_t pend_mem [ListLen];
	int pend_wr = 0;
	int pend_rd = 0;
	projected_t exp_mem [ListLen];
	int exp_wr = 0;
	int exp_rd = 0;
	int errors = 0;
	int idle_pct = 0;

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] lane(input logic [63:0] c, input int k);
		logic [15:0] f;
		f = c[16*k +: 16];
		return {{48{f[15]}}, f};
	endfunction

	function automatic logic signed [63:0] dot(input logic [63:0] c,
			input logic signed [63:0] x, input logic signed [63:0] y,
			input logic signed [63:0] z);
		return x * lane(c, 0) + y * lane(c, 1) + z * lane(c, 2) + lane(c, 3) * 65536;
	endfunction

	function automatic logic signed [63:0] persp_div(input logic signed [63:0] n,
			input logic signed [63:0] w);
		logic neg;
		logic [127:0] un, uw, q;
		logic signed [63:0] mag;
		neg = (n < 0) != (w < 0);
		un = n < 0 ? -n : n;
		uw = w < 0 ? -w : w;
		q = (un << 16) / uw;
		if (q > (128'd1 << 48)) begin
			q = 128'd1 << 48;
		end
		mag = q[63:0];
		return clamp32(neg ? -mag : mag);
	endfunction

	function automatic logic signed [63:0] to_screen(input logic signed [63:0] v,
			input int size);
		return clamp32(((v + 65536) * size) >>> 1);
	endfunction

	function automatic projected_t project(input vertex_t v);
		projected_t r;
		logic signed [63:0] x, y, z, nx, ny, nz, w, rx, ry, rz;
		x = 64'(v.x) + ofs[0];
		y = 64'(v.y) + ofs[1];
		z = 64'(v.z) + ofs[2];
		nx = dot(coef[0], x, y, z);
		ny = dot(coef[1], x, y, z);
		nz = dot(coef[2], x, y, z);
		w = dot(coef[3], x, y, z);
		if (w != 0) begin
			rx = persp_div(nx, w);
			ry = persp_div(ny, w);
			rz = persp_div(nz, w);
			r.wz = 1'b0;
		end else begin
			rx = clamp32(nx >>> 12);
			ry = clamp32(ny >>> 12);
			rz = clamp32(nz >>> 12);
			r.wz = 1'b1;
		end
		if (view_on) begin
			rx = to_screen(rx, 2560);
			ry = to_screen(ry, 1440);
		end
		r.x = rx[31:0];
		r.y = ry[31:0];
		r.z = rz[31:0];
		return r;
	endfunction

	// Driver: one vertex per accepted beat.
	always @(posedge clk) begin
		vertex_t nv;
		if (arst_n && start && !busy) begin
			exp_mem[exp_wr % ListLen] = project('{vertex_x, vertex_y, vertex_z});
			exp_wr++;
			pend_rd++;
		end
		if (arst_n && pend_wr > pend_rd && $urandom_range(99) >= idle_pct) begin
			nv = pend_mem[pend_rd % ListLen];
			start <= 1'b1;
			vertex_x <= nv.x;
			vertex_y <= nv.y;
			vertex_z <= nv.z;
		end else if (!(start && busy)) begin
			start <= 1'b0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			projected_t e;
			if (exp_rd == exp_wr) begin
				$display("%0t: unexpected result %h %h %h %b", $time,
					result_x, result_y, result_z, w_was_zero);
				errors++;
			end else begin
				e = exp_mem[exp_rd % ListLen];
				exp_rd++;
				if (e.x !== result_x) begin
					$display("%0t: x expected %h actual %h", $time, e.x, result_x);
					errors++;
				end
				if (e.y !== result_y) begin
					$display("%0t: y expected %h actual %h", $time, e.y, result_y);
					errors++;
				end
				if (e.z !== result_z) begin
					$display("%0t: z expected %h actual %h", $time, e.z, result_z);
					errors++;
				end
				if (e.wz !== w_was_zero) begin
					$display("%0t: w_was_zero expected %b actual %b", $time,
						e.wz, w_was_zero);
					errors++;
				end
			end
		end
	end

	task automatic add_vertex(input vertex_t v);
		pend_mem[pend_wr % ListLen] = v;
		pend_wr++;
	endtask

	task automatic write_reg(input vtp_pkg::reg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vtp_pkg::REG_COEF_X, vtp_pkg::REG_COEF_Y, vtp_pkg::REG_COEF_Z,
			vtp_pkg::REG_COEF_W: coef[idx] = val;
			vtp_pkg::REG_OFS_X: ofs[0] = {{32{val[31]}}, val[31:0]};
			vtp_pkg::REG_OFS_Y: ofs[1] = {{32{val[31]}}, val[31:0]};
			vtp_pkg::REG_OFS_Z: ofs[2] = {{32{val[31]}}, val[31:0]};
			default: view_on = val[0];
		endcase
	endtask

	task automatic drain;
		while (pend_rd != pend_wr || exp_rd != exp_wr) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(8) << 16;
			3: return $urandom() >>> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] rand_lane();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h1000;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_config(input int mode);
		logic [63:0] c;
		for (int i = 0; i < 4; i++) begin
			c = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
			// Some settings keep w identically zero to exercise the skipped divide.
			if (i == 3 && mode == 1) begin
				c = 64'h0;
			end
			write_reg(vtp_pkg::reg_idx_t'(i), c);
		end
		for (int i = 4; i < 7; i++) begin
			write_reg(vtp_pkg::reg_idx_t'(i), mode == 2 ? 64'h0 : {$urandom(), rand_coord()});
		end
		write_reg(vtp_pkg::REG_VIEW, {$urandom(), $urandom()});
	endtask

	initial begin
		vertex_t dv [6];
		coef[0] = 64'd4096;
		coef[1] = 64'd4096 << 16;
		coef[2] = 64'd4096 << 32;
		coef[3] = 64'd4096 << 48;
		ofs[0] = 0; ofs[1] = 0; ofs[2] = 0;
		view_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dv[0] = '{32'sh0, 32'sh0, 32'sh0};
		dv[1] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		dv[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		dv[3] = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0002_8000};
		dv[4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001};
		dv[5] = '{-32'sh1, 32'sh1, -32'sh1};
		foreach (dv[i]) add_vertex(dv[i]);
		drain();
		// Extreme coefficients, offsets, viewport on, and w driven to zero.
		write_reg(vtp_pkg::REG_COEF_X, 64'h8000_7FFF_8000_7FFF);
		write_reg(vtp_pkg::REG_COEF_Y, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(vtp_pkg::REG_COEF_Z, 64'h8000_8000_8000_8000);
		write_reg(vtp_pkg::REG_COEF_W, 64'h0000_0000_0000_0000);
		write_reg(vtp_pkg::REG_OFS_X, 64'h7FFF_FFFF);
		write_reg(vtp_pkg::REG_OFS_Y, 64'h8000_0000);
		write_reg(vtp_pkg::REG_OFS_Z, 64'hFFFF_FFFF);
		write_reg(vtp_pkg::REG_VIEW, 64'h1);
		for (int i = 0; i < 6; i++) add_vertex(dv[i]);
		drain();
		// Small w gives quotient saturation.
		write_reg(vtp_pkg::REG_COEF_W, 64'h0000_0000_0000_0001);
		write_reg(vtp_pkg::REG_VIEW, 64'h0);
		for (int i = 0; i < 6; i++) add_vertex(dv[i]);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 86;
				2: idle_pct = 0;
				default: idle_pct = 31;
			endcase
			random_config(ph % 3);
			for (int n = 0; n < 125; n++) begin
				add_vertex('{rand_coord(), rand_coord(), rand_coord()});
			end
			drain();
		end
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
